// ===== rtl/sample_packet_framer_crc16_unit_assert.svh =====
// Assertion macros for the sample packet framer.
// Included by the top level; the macros expand to nothing when SYNTH is defined.
`ifndef SAMPLE_PACKET_FRAMER_CRC16_UNIT_ASSERT_SVH
`define SAMPLE_PACKET_FRAMER_CRC16_UNIT_ASSERT_SVH
`ifndef SYNTH
// check on every clock edge outside reset
`define SPFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define SPFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPFC_ASSERT(lbl, prop, msg)
`define SPFC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/spfc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the sample packet framer.
// No dependencies.
package spfc_pkg;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [31:0] HEADER_RESET = 32'hAABBCCDD;

    localparam int MIN_PKT_LEN = 2;
    localparam int MAX_PKT_LEN = 128;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one accepted sample with its place in the packet
    typedef struct packed {
        logic [31:0] header;
        logic [15:0] sample;
        logic        first;
        logic        last;
    } entry_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

    typedef enum logic [3:0] {
        PH_START,
        PH_HDR3,
        PH_HDR2,
        PH_HDR1,
        PH_HDR0,
        PH_LO,
        PH_HI,
        PH_CRCH,
        PH_CRCL
    } phase_t;

    // reflected CRC-16, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/sample_packet_framer_crc16_unit.sv =====
// An accepted item is written to the queue entry and then to the output register before
// its first byte is valid, when the queue is empty and the output register is free.
// One output byte per cycle from the byte sequencer while the receiver is ready; an item
// yields 6 bytes at packet start, 2 mid-packet and 4 at packet end (2*N+6 per N-sample packet).
// A four-entry queue lets input keep arriving while the output stalls.
// Reset (rst_n low, asynchronous): header 0xAABBCCDD, packet position 0, queue empty,
// CRC 0xFFFF, no output valid.
`include "sample_packet_framer_crc16_unit_assert.svh"

module sample_packet_framer_crc16_unit #(
    parameter int SAMPLES_PER_PACKET = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,   // header_pattern
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast     // packet_end
);

    spfc_pkg::entry_t    push_entry;
    spfc_pkg::entry_t    head;
    spfc_pkg::q_status_t q_stat;
    logic                push;
    logic                pop;

    spfc_front #(
        .SAMPLES_PER_PACKET(SAMPLES_PER_PACKET)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    spfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    spfc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `SPFC_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n |=> !m_tvalid, "output valid during reset")
    `SPFC_ASSERT(a_no_push_full, push |-> !q_stat.full, "push into full queue")
    `SPFC_ASSERT(a_no_pop_empty, pop |-> !q_stat.empty, "pop from empty queue")
    `SPFC_ASSERT(a_count_step, (push && !pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1),
        "queue count did not advance on push")

endmodule

// ===== rtl/spfc_front.sv =====
// Front end: holds the header register, accepts samples and tags first/last of a packet.
// Depends on spfc_pkg.
module spfc_front #(
    parameter int SAMPLES_PER_PACKET = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] sample
    input  spfc_pkg::q_status_t q_stat,
    output logic                push,
    output spfc_pkg::entry_t    push_entry
);

    localparam int PKT_LEN = (SAMPLES_PER_PACKET < spfc_pkg::MIN_PKT_LEN) ? spfc_pkg::MIN_PKT_LEN :
                             (SAMPLES_PER_PACKET > spfc_pkg::MAX_PKT_LEN) ? spfc_pkg::MAX_PKT_LEN :
                             SAMPLES_PER_PACKET;
    localparam int IDX_W = $clog2(PKT_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PKT_LEN - 1);

    logic [31:0]      header_reg;
    logic [31:0]      header_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             is_first;
    logic             is_last;

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;
    assign is_first = (idx_reg == '0);
    assign is_last  = (idx_reg == LAST_IDX);

    assign push_entry.header = header_reg;
    assign push_entry.sample = s_tdata;
    assign push_entry.first  = is_first;
    assign push_entry.last   = is_last;

    always_comb
    begin
        header_next = cfg_we ? cfg_data : header_reg;
        idx_next    = idx_reg;
        if (push)
            idx_next = is_last ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= spfc_pkg::HEADER_RESET;
            idx_reg    <= '0;
        end
        else
        begin
            header_reg <= header_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

// ===== rtl/spfc_queue.sv =====
// Short FIFO of tagged samples between the front end and the byte sequencer.
// Depends on spfc_pkg.
module spfc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  spfc_pkg::entry_t    push_entry,
    input  logic                pop,
    output spfc_pkg::entry_t    head,
    output spfc_pkg::q_status_t q_stat
);

    localparam logic [spfc_pkg::QCNT_W-1:0] FULL_CNT = spfc_pkg::QCNT_W'(spfc_pkg::QUEUE_DEPTH);

    spfc_pkg::entry_t              entries_reg [spfc_pkg::QUEUE_DEPTH];
    logic [spfc_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [spfc_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [spfc_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [spfc_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [spfc_pkg::QCNT_W-1:0]   count_reg;
    logic [spfc_pkg::QCNT_W-1:0]   count_next;

    assign head         = entries_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == FULL_CNT);
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.count = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/spfc_back.sv =====
// Back end: walks the bytes of each queued sample, runs the CRC, drives the output register.
// Depends on spfc_pkg.
module spfc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  spfc_pkg::entry_t    head,
    input  spfc_pkg::q_status_t q_stat,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] out_byte
    output logic                m_tlast    // packet_end
);

    spfc_pkg::phase_t phase_reg;
    spfc_pkg::phase_t phase_next;
    spfc_pkg::phase_t cur_phase;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic             adv;
    logic             emit;
    logic [7:0]       byte_val;
    logic             byte_end;
    logic             byte_crc;
    logic [15:0]      crc_base;

    assign adv  = !out_valid_reg || m_tready;
    assign emit = !q_stat.empty && adv;

    // a fresh head entry starts at its header or at its sample bytes
    always_comb
    begin
        if (phase_reg == spfc_pkg::PH_START)
            cur_phase = head.first ? spfc_pkg::PH_HDR3 : spfc_pkg::PH_LO;
        else
            cur_phase = phase_reg;
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        pop        = 1'b0;
        if (emit)
        begin
            unique case (cur_phase)
                spfc_pkg::PH_HDR3: phase_next = spfc_pkg::PH_HDR2;
                spfc_pkg::PH_HDR2: phase_next = spfc_pkg::PH_HDR1;
                spfc_pkg::PH_HDR1: phase_next = spfc_pkg::PH_HDR0;
                spfc_pkg::PH_HDR0: phase_next = spfc_pkg::PH_LO;
                spfc_pkg::PH_LO:   phase_next = spfc_pkg::PH_HI;
                spfc_pkg::PH_HI:
                begin
                    if (head.last)
                        phase_next = spfc_pkg::PH_CRCH;
                    else
                    begin
                        phase_next = spfc_pkg::PH_START;
                        pop        = 1'b1;
                    end
                end
                spfc_pkg::PH_CRCH: phase_next = spfc_pkg::PH_CRCL;
                spfc_pkg::PH_CRCL:
                begin
                    phase_next = spfc_pkg::PH_START;
                    pop        = 1'b1;
                end
                default:           phase_next = spfc_pkg::PH_START;
            endcase
        end
    end

    // outputs of the current phase
    always_comb
    begin
        byte_val = 8'h00;
        byte_end = 1'b0;
        byte_crc = 1'b0;
        crc_base = crc_reg;
        unique case (cur_phase)
            spfc_pkg::PH_HDR3:
            begin
                byte_val = head.header[31:24];
                byte_crc = 1'b1;
                crc_base = spfc_pkg::CRC_INIT;
            end
            spfc_pkg::PH_HDR2:
            begin
                byte_val = head.header[23:16];
                byte_crc = 1'b1;
            end
            spfc_pkg::PH_HDR1:
            begin
                byte_val = head.header[15:8];
                byte_crc = 1'b1;
            end
            spfc_pkg::PH_HDR0:
            begin
                byte_val = head.header[7:0];
                byte_crc = 1'b1;
            end
            spfc_pkg::PH_LO:
            begin
                byte_val = head.sample[7:0];
                byte_crc = 1'b1;
            end
            spfc_pkg::PH_HI:
            begin
                byte_val = head.sample[15:8];
                byte_crc = 1'b1;
            end
            spfc_pkg::PH_CRCH: byte_val = crc_reg[15:8];
            spfc_pkg::PH_CRCL:
            begin
                byte_val = crc_reg[7:0];
                byte_end = 1'b1;
            end
            default:           byte_val = 8'h00;
        endcase
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (emit && byte_crc)
            crc_next = spfc_pkg::crc_byte(crc_base, byte_val);
        out_valid_next = adv ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= spfc_pkg::PH_START;
            crc_reg       <= spfc_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload while the output waits
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= byte_val;
            out_last_reg <= byte_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== verif/tb_sample_packet_framer_crc16_unit.sv =====
// Self-checking testbench for sample_packet_framer_crc16_unit: drives samples, predicts
// the framed byte stream (header, data, Modbus CRC-16) and checks every output item.
// Depends on spfc_pkg and the framer RTL.
`timescale 1ns / 100ps

module tb_sample_packet_framer_crc16_unit;

    localparam int SPP            = 16;
    localparam int PKT_LEN        = (SPP < spfc_pkg::MIN_PKT_LEN) ? spfc_pkg::MIN_PKT_LEN :
                                    (SPP > spfc_pkg::MAX_PKT_LEN) ? spfc_pkg::MAX_PKT_LEN :
                                    SPP;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT    = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       eop;
    } octet_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [15:0] sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] out_byte
    logic        m_tlast;           // packet_end

    // predictor state
    logic [31:0] header_shadow = spfc_pkg::HEADER_RESET;
    logic [15:0] crc_run       = spfc_pkg::CRC_INIT;
    int          pkt_pos       = 0;

    logic [15:0] samples_to_send[$];
    octet_t      expected_octets[$];

    // field extremes and bit patterns
    logic [15:0] corner_samples[18] = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001,
        16'h8000, 16'h00FF, 16'hFF00, 16'h1234, 16'hFEDC, 16'h7FFF, 16'h8001,
        16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3, 16'hFFFF, 16'h0000};

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    sample_packet_framer_crc16_unit #(
        .SAMPLES_PER_PACKET(SPP)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // reflected CRC-16 update, LSB shifted out first
    function automatic logic [15:0] crc_after_octet(input logic [15:0] crc,
                                                    input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        repeat (8)
        begin
            r = r[0] ? ((r >> 1) ^ spfc_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic emit_octet(input logic [7:0] b, input logic eop);
        expected_octets.push_back('{data: b, eop: eop});
        crc_run = crc_after_octet(crc_run, b);
    endtask

    task automatic frame_sample(input logic [15:0] s);
        logic [15:0] c;
        if (pkt_pos == 0)
        begin
            crc_run = spfc_pkg::CRC_INIT;
            for (int i = 3; i >= 0; i--)
                emit_octet(header_shadow[8*i +: 8], 1'b0);
        end
        emit_octet(s[7:0], 1'b0);
        emit_octet(s[15:8], 1'b0);
        pkt_pos++;
        if (pkt_pos == PKT_LEN)
        begin
            // CRC goes out high byte first and is not folded into itself
            c = crc_run;
            expected_octets.push_back('{data: c[15:8], eop: 1'b0});
            expected_octets.push_back('{data: c[7:0], eop: 1'b1});
            pkt_pos = 0;
            crc_run = spfc_pkg::CRC_INIT;
        end
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                frame_sample(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (samples_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    s_tdata  <= samples_to_send.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // byte monitor and receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin : byte_monitor
        octet_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_octets.size() == 0)
                begin
                    $error("unexpected item: out_byte %02h packet_end %0b", m_tdata, m_tlast);
                    error_count++;
                end
                else
                begin
                    want = expected_octets.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        $error("out_byte expected %02h actual %02h", want.data, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.eop)
                    begin
                        $error("packet_end expected %0b actual %0b", want.eop, m_tlast);
                        error_count++;
                    end
                end
            end
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic set_idling(input int tx, input int rx);
        @(posedge clk);
        tx_idle_pct <= tx;
        rx_idle_pct <= rx;
    endtask

    task automatic queue_random(input int n);
        @(negedge clk);
        repeat (n)
            samples_to_send.push_back(16'($urandom_range(16'hFFFF)));
    endtask

    // hold until every pending sample is taken and every item has come out
    task automatic drain();
        @(negedge clk);
        while (samples_to_send.size() != 0 || s_tvalid || expected_octets.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_header(input logic [31:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        header_shadow = value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, a full packet with the reset header, then two more
        set_idling(33, 33);
        @(negedge clk);
        foreach (corner_samples[i])
            samples_to_send.push_back(corner_samples[i]);
        drain();

        // header written mid-packet: the open packet keeps the old header
        write_header(32'h0000_0000);
        queue_random(30);
        drain();

        write_header(32'hFFFF_FFFF);
        set_idling(0, 0);
        queue_random(32);
        drain();

        // receiver holds off while the sender keeps offering
        write_header($urandom);
        set_idling(0, 33);
        @(posedge clk);
        hold_requests <= hold_requests + 1;
        queue_random(25);
        drain();

        write_header($urandom);
        set_idling(33, 33);
        queue_random(15);
        drain();

        repeat (10) @(posedge clk);
        if (expected_octets.size() != 0)
        begin
            $error("%0d expected items never arrived", expected_octets.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
